// File: rtl/assert_macros.svh
// assertion macros shared by the frame builder rtl
// no dependencies; expects clk_i and rst_ni in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define MFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define MFB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/mfb_pkg.sv
// shared types, constants and crc function of the modbus frame builder
// no dependencies
`default_nettype none

package mfb_pkg;

  // front/back queue sizing
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // config port
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;

  // modbus crc-16, reflected
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // register index (word address)
  typedef enum logic [1:0] {
    REG_SLAVE_ADDR = 2'd0,
    REG_FUNC_CODE  = 2'd1,
    REG_PARAM_CODE = 2'd2
  } mfb_reg_e;

  // one queued payload beat with its frame header snapshot
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        first;
    logic [7:0]  slave_addr;
    logic [7:0]  func_code;
    logic [15:0] param_code;
  } mfb_entry_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } mfb_qstat_t;

  // one byte of crc update, lsb first
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mfb_if.sv
// stream interfaces of the frame builder: payload in, wire bytes out
// no dependencies
`default_nettype none

// payload byte stream
interface mfb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// framed byte stream
interface mfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;

  modport source (output valid, output out_byte, output frame_end, input ready);
  modport sink   (input valid, input out_byte, input frame_end, output ready);
endinterface

`default_nettype wire

// File: rtl/mfb_front.sv
// front end: accepts payload beats, marks frame start, snapshots the header
// depends on mfb_pkg and mfb_in_if
`default_nettype none

module mfb_front
  import mfb_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  mfb_in_if.sink       in_if,
  input  logic [7:0]   slave_addr_i,
  input  logic [7:0]   func_code_i,
  input  logic [15:0]  param_code_i,
  input  mfb_qstat_t   qstat_i,
  output logic         push_o,
  output mfb_entry_t   entry_o
);

  logic in_frame_q, in_frame_d;

  // take a beat whenever the queue has room
  assign in_if.ready = !qstat_i.full;
  assign push_o      = in_if.valid && in_if.ready;

  // classify and attach header values current at frame start
  always_comb begin
    entry_o.data       = in_if.data_byte;
    entry_o.last       = in_if.last_byte;
    entry_o.first      = !in_frame_q;
    entry_o.slave_addr = slave_addr_i;
    entry_o.func_code  = func_code_i;
    entry_o.param_code = param_code_i;
  end

  // frame tracking
  always_comb begin
    in_frame_d = in_frame_q;
    if (push_o) begin
      in_frame_d = !in_if.last_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mfb_queue.sv
// small queue between front and back end
// depends on mfb_pkg
`default_nettype none

module mfb_queue
  import mfb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  mfb_entry_t  entry_i,
  input  logic        pop_i,
  output mfb_entry_t  entry_o,
  output mfb_qstat_t  qstat_o
);

  mfb_entry_t       mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;

  assign qstat_o.full  = (count_q == QCntW'(QDepth));
  assign qstat_o.empty = (count_q == '0);
  assign entry_o       = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mfb_back.sv
// back end: byte sequencer for header, payload and crc trailer
// depends on mfb_pkg and mfb_out_if
`default_nettype none

module mfb_back
  import mfb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mfb_entry_t  entry_i,
  input  mfb_qstat_t  qstat_i,
  output logic        pop_o,
  output logic        at_start_o,
  mfb_out_if.source   out_if
);

  typedef enum logic [2:0] {
    PH_START,
    PH_HDR0,
    PH_HDR1,
    PH_HDR2,
    PH_HDR3,
    PH_DATA,
    PH_CRC_LO,
    PH_CRC_HI
  } phase_e;

  phase_e      phase_q, next_ph, eff_ph;
  logic [15:0] crc_q, crc_next;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_end_q;
  logic        head_valid, adv, fire;
  logic [7:0]  byte_sel;
  logic        end_sel, feed_crc;

  assign head_valid = !qstat_i.empty;
  assign adv        = !out_valid_q || out_if.ready;
  assign fire       = adv && head_valid;
  assign at_start_o = (phase_q == PH_START);

  // a fresh entry opens with the header only on a new frame
  always_comb begin
    if (phase_q == PH_START) begin
      eff_ph = entry_i.first ? PH_HDR0 : PH_DATA;
    end else begin
      eff_ph = phase_q;
    end
  end

  // byte select and next phase
  always_comb begin
    byte_sel = entry_i.data;
    end_sel  = 1'b0;
    feed_crc = 1'b0;
    next_ph  = PH_START;
    unique case (eff_ph)
      PH_HDR0: begin
        byte_sel = entry_i.slave_addr;
        feed_crc = 1'b1;
        next_ph  = PH_HDR1;
      end
      PH_HDR1: begin
        byte_sel = entry_i.func_code;
        feed_crc = 1'b1;
        next_ph  = PH_HDR2;
      end
      PH_HDR2: begin
        byte_sel = entry_i.param_code[15:8];
        feed_crc = 1'b1;
        next_ph  = PH_HDR3;
      end
      PH_HDR3: begin
        byte_sel = entry_i.param_code[7:0];
        feed_crc = 1'b1;
        next_ph  = PH_DATA;
      end
      PH_DATA: begin
        byte_sel = entry_i.data;
        feed_crc = 1'b1;
        next_ph  = entry_i.last ? PH_CRC_LO : PH_START;
      end
      PH_CRC_LO: begin
        byte_sel = crc_q[7:0];
        next_ph  = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        byte_sel = crc_q[15:8];
        end_sel  = 1'b1;
        next_ph  = PH_START;
      end
      default: begin
        byte_sel = entry_i.data;
        next_ph  = PH_START;
      end
    endcase
  end

  assign crc_next = crc16_byte(crc_q, byte_sel);

  // entry leaves the queue with its final byte
  assign pop_o = fire && (((eff_ph == PH_DATA) && !entry_i.last) || (eff_ph == PH_CRC_HI));

  // sequencer state, running crc and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      crc_q       <= CrcInit;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_end_q   <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_q <= head_valid;
      end
      if (fire) begin
        out_byte_q <= byte_sel;
        out_end_q  <= end_sel;
        phase_q    <= next_ph;
        if (feed_crc) begin
          crc_q <= crc_next;
        end else if (eff_ph == PH_CRC_HI) begin
          crc_q <= CrcInit;
        end
      end
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.out_byte  = out_byte_q;
  assign out_if.frame_end = out_end_q;

endmodule

`default_nettype wire

// File: rtl/modbus_frame_builder_crc16_core.sv
// top level of the modbus rtu frame builder with crc-16
// depends on mfb_pkg, mfb_if, mfb_front, mfb_queue, mfb_back, assert_macros.svh
`default_nettype none

// Turns payload beats into Modbus RTU frames: the first beat of a frame is
// preceded by slave address, function code and parameter code (high byte
// first), and the beat marked last is followed by the CRC-16 low then high
// byte, the high byte carrying frame_end. The output moves one byte per
// clock while a beat is queued and out_if.ready does not hold it back;
// every byte comes from the single byte sequencer in the back end. A
// four-entry queue, the beat in progress included, lets the input keep
// taking beats while trailer or header bytes drain; once it is full the
// input waits for the sequencer to release a beat. Header registers are
// sampled when a frame's first beat is accepted.
module modbus_frame_builder_crc16_core
  import mfb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  mfb_in_if.sink              in_if,
  mfb_out_if.source           out_if
);

  `include "assert_macros.svh"

  logic [7:0]  slave_addr_q;
  logic [7:0]  func_code_q;
  logic [15:0] param_code_q;
  logic        cfg_wr;
  logic        push, pop, back_at_start;
  mfb_entry_t  push_entry, head_entry;
  mfb_qstat_t  qstat;

  // config registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= 8'd1;
      func_code_q  <= 8'd6;
      param_code_q <= 16'd0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_SLAVE_ADDR: slave_addr_q <= pwdata[7:0];
        REG_FUNC_CODE:  func_code_q  <= pwdata[7:0];
        REG_PARAM_CODE: param_code_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[3:2])
      REG_SLAVE_ADDR: prdata = {24'd0, slave_addr_q};
      REG_FUNC_CODE:  prdata = {24'd0, func_code_q};
      REG_PARAM_CODE: prdata = {16'd0, param_code_q};
      default:        prdata = '0;
    endcase
  end

  mfb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_if        (in_if),
    .slave_addr_i (slave_addr_q),
    .func_code_i  (func_code_q),
    .param_code_i (param_code_q),
    .qstat_i      (qstat),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  mfb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .qstat_o (qstat)
  );

  mfb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .entry_i    (head_entry),
    .qstat_i    (qstat),
    .pop_o      (pop),
    .at_start_o (back_at_start),
    .out_if     (out_if)
  );

  // no output beat offered while in reset
  `MFB_ASSERT_ALWAYS(a_rst_no_out, !rst_ni |-> !out_if.valid, "output valid during reset")
  // an accepted input beat is queued on the next cycle
  `MFB_ASSERT(a_push_lands, (in_if.valid && in_if.ready) |=> !qstat.empty, "accepted beat lost")
  // the sequencer is never mid-entry with nothing queued
  `MFB_ASSERT(a_empty_idle, qstat.empty |-> back_at_start, "sequencer busy on empty queue")

endmodule

`default_nettype wire
